// ===== src/dtps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtps_pkg;

    localparam int WIDTH_BITS  = 9;
    localparam int HEIGHT_BITS = 8;
    // Product of a 9-bit width and an 8-bit height, and any index below it
    localparam int AREA_BITS   = WIDTH_BITS + HEIGHT_BITS;
    localparam int WORD_BITS   = 32;

    typedef enum logic [1:0] {
        OP_DRAW        = 2'd0,
        OP_CLEAR_DEPTH = 2'd1,
        OP_CLEAR_PIXEL = 2'd2,
        OP_READ        = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_CLEAR_DEPTH   = 3'd2,
        REG_DEPTH_FLOOR   = 3'd3,
        REG_DEPTH_CEILING = 3'd4,
        REG_CLEAR_PIXEL   = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        STAT_WRITTEN      = 3'd0,
        STAT_CLIPPED      = 3'd1,
        STAT_REJECTED     = 3'd2,
        STAT_CLEARED      = 3'd3,
        STAT_READ_OK      = 3'd4,
        STAT_READ_OUTSIDE = 3'd5
    } status_t;

    // What the back end has to do with a classified request
    typedef enum logic [2:0] {
        K_DRAW       = 3'd0,
        K_CLIP       = 3'd1,
        K_FILL_DEPTH = 3'd2,
        K_FILL_PIXEL = 3'd3,
        K_FILL_NONE  = 3'd4,
        K_READ       = 3'd5,
        K_READ_OUT   = 3'd6
    } kind_t;

    // value: draw depth, or the word a fill writes
    typedef struct packed {
        kind_t                 kind;
        logic [WORD_BITS-1:0]  value;
        logic [WORD_BITS-1:0]  word;
        logic                  last;
    } cmd_info_t;

    typedef struct packed {
        status_t                     status;
        logic [WORD_BITS-1:0]        pixel;
        logic signed [WORD_BITS-1:0] depth;
        logic                        last;
    } res_t;

endpackage

`default_nettype wire

// ===== src/dtps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/dtps_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/dtps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtps_front
    import dtps_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128,
    parameter int AW         = 15
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [WORD_BITS-1:0]        cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [1:0]                  opcode,
    input  wire logic signed [15:0]          pos_x,
    input  wire logic signed [15:0]          pos_y,
    input  wire logic signed [WORD_BITS-1:0] pos_z,
    input  wire logic [WORD_BITS-1:0]        pixel_word,
    input  wire logic                        batch_last,
    input  wire logic                        init_busy,
    input  wire logic                        cmd_pop,
    output logic                             cmd_empty,
    output cmd_info_t                        cmd_info,
    output logic [AW-1:0]                    cmd_addr
);

    localparam int CMD_BITS = $bits(cmd_info_t) + AW;

    logic [WIDTH_BITS-1:0]        screen_width_reg;
    logic [HEIGHT_BITS-1:0]       screen_height_reg;
    logic signed [WORD_BITS-1:0]  clear_depth_reg;
    logic signed [WORD_BITS-1:0]  depth_floor_reg;
    logic signed [WORD_BITS-1:0]  depth_ceiling_reg;
    logic [WORD_BITS-1:0]         clear_pixel_reg;

    logic [WIDTH_BITS-1:0]        act_w;
    logic [HEIGHT_BITS-1:0]       act_h;
    logic                         on_screen;
    logic [AREA_BITS-1:0]         idx;
    logic [AREA_BITS-1:0]         area;
    logic signed [WORD_BITS-1:0]  fill_depth;
    cmd_info_t                    in_info;
    logic [AW-1:0]                in_addr;
    logic                         cmd_full;
    logic                         accept;
    logic [CMD_BITS-1:0]          q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= WIDTH_BITS'(256);
            screen_height_reg <= HEIGHT_BITS'(128);
            clear_depth_reg   <= '0;
            depth_floor_reg   <= {1'b1, {(WORD_BITS-1){1'b0}}};
            depth_ceiling_reg <= {1'b0, {(WORD_BITS-1){1'b1}}};
            clear_pixel_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                REG_CLEAR_DEPTH:   clear_depth_reg   <= cfg_data;
                REG_DEPTH_FLOOR:   depth_floor_reg   <= cfg_data;
                REG_DEPTH_CEILING: depth_ceiling_reg <= cfg_data;
                REG_CLEAR_PIXEL:   clear_pixel_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Limit geometry to the store
    assign act_w = (int'(screen_width_reg) > MAX_WIDTH) ?
                   WIDTH_BITS'(MAX_WIDTH) : screen_width_reg;
    assign act_h = (int'(screen_height_reg) > MAX_HEIGHT) ?
                   HEIGHT_BITS'(MAX_HEIGHT) : screen_height_reg;

    assign on_screen = !pos_x[15] && !pos_y[15]
                    && (pos_x[14:0] < 15'(act_w))
                    && (pos_y[14:0] < 15'(act_h));

    // Only meaningful when on screen: then x < w and y < h
    assign idx  = AREA_BITS'(pos_y[HEIGHT_BITS-1:0]) * AREA_BITS'(act_w)
                + AREA_BITS'(pos_x[WIDTH_BITS-1:0]);
    assign area = AREA_BITS'(act_h) * AREA_BITS'(act_w);

    // When the two cross, a depth below the floor takes the floor, any other the ceiling
    always_comb
    begin
        fill_depth = clear_depth_reg;
        if (clear_depth_reg < depth_floor_reg)
        begin
            fill_depth = depth_floor_reg;
        end
        else if (clear_depth_reg > depth_ceiling_reg)
        begin
            fill_depth = depth_ceiling_reg;
        end
    end

    always_comb
    begin
        in_info.kind  = K_CLIP;
        in_info.value = '0;
        in_info.word  = pixel_word;
        in_info.last  = batch_last;
        in_addr       = AW'(idx);
        case (opcode)
            OP_DRAW:
            begin
                in_info.kind  = on_screen ? K_DRAW : K_CLIP;
                in_info.value = pos_z;
            end
            OP_CLEAR_DEPTH:
            begin
                in_info.kind  = (area == '0) ? K_FILL_NONE : K_FILL_DEPTH;
                in_info.value = fill_depth;
                in_addr       = AW'(area - 1'b1);
            end
            OP_CLEAR_PIXEL:
            begin
                in_info.kind  = (area == '0) ? K_FILL_NONE : K_FILL_PIXEL;
                in_info.value = clear_pixel_reg;
                in_addr       = AW'(area - 1'b1);
            end
            OP_READ:
            begin
                in_info.kind = on_screen ? K_READ : K_READ_OUT;
            end
            default:
            begin
                in_info.kind = K_CLIP;
            end
        endcase
    end

    assign full   = cmd_full || init_busy;
    assign accept = push && !full;

    dtps_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata ({in_info, in_addr}),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (q_out),
        .empty (cmd_empty)
    );

    assign cmd_info = q_out[CMD_BITS-1:AW];
    assign cmd_addr = q_out[AW-1:0];

endmodule

`default_nettype wire

// ===== src/dtps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtps_back
    import dtps_pkg::*;
#(
    parameter int STORE = 32768,
    parameter int AW    = 15
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               init_busy,
    output logic               cmd_pop,
    input  wire logic          cmd_empty,
    input  wire cmd_info_t     cmd_info,
    input  wire logic [AW-1:0] cmd_addr,
    input  wire logic          res_pop,
    output logic               res_empty,
    output res_t               res_data
);

    localparam int RES_BITS = $bits(res_t);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DRAW,
        S_READ,
        S_FILL
    } state_t;

    state_t               state_reg;
    logic [AW-1:0]        cnt_reg;
    cmd_info_t            info_reg;
    logic [AW-1:0]        addr_reg;

    logic                 res_full;
    logic                 res_push;
    res_t                 res_in;
    logic [RES_BITS-1:0]  res_q;

    logic                 d_we, p_we, rd_en;
    logic [AW-1:0]        waddr;
    logic [WORD_BITS-1:0] d_wdata, p_wdata;
    logic [WORD_BITS-1:0] d_rdata, p_rdata;
    logic                 depth_pass;

    assign init_busy  = (state_reg == S_INIT);
    assign cmd_pop    = (state_reg == S_IDLE) && !cmd_empty && !res_full;
    // Larger or equal depth wins
    assign depth_pass = $signed(info_reg.value) >= $signed(d_rdata);

    always_comb
    begin
        d_we        = 1'b0;
        p_we        = 1'b0;
        rd_en       = cmd_pop;
        waddr       = addr_reg;
        d_wdata     = info_reg.value;
        p_wdata     = info_reg.word;
        res_push    = 1'b0;
        res_in      = '0;
        res_in.last = info_reg.last;
        case (state_reg)
            S_INIT:
            begin
                d_we    = 1'b1;
                p_we    = 1'b1;
                waddr   = cnt_reg;
                d_wdata = '0;
                p_wdata = '0;
            end
            S_IDLE:
            begin
                res_in.last = cmd_info.last;
                if (cmd_pop)
                begin
                    case (cmd_info.kind)
                        K_CLIP:
                        begin
                            res_push      = 1'b1;
                            res_in.status = STAT_CLIPPED;
                        end
                        K_READ_OUT:
                        begin
                            res_push      = 1'b1;
                            res_in.status = STAT_READ_OUTSIDE;
                        end
                        K_FILL_NONE:
                        begin
                            res_push      = 1'b1;
                            res_in.status = STAT_CLEARED;
                        end
                        default: ;
                    endcase
                end
            end
            S_DRAW:
            begin
                res_push = 1'b1;
                if (depth_pass)
                begin
                    d_we          = 1'b1;
                    p_we          = 1'b1;
                    res_in.status = STAT_WRITTEN;
                end
                else
                begin
                    res_in.status = STAT_REJECTED;
                end
            end
            S_READ:
            begin
                res_push      = 1'b1;
                res_in.status = STAT_READ_OK;
                res_in.pixel  = p_rdata;
                res_in.depth  = d_rdata;
            end
            S_FILL:
            begin
                waddr   = cnt_reg;
                p_wdata = info_reg.value;
                if (info_reg.kind == K_FILL_DEPTH)
                begin
                    d_we = 1'b1;
                end
                else
                begin
                    p_we = 1'b1;
                end
                if (cnt_reg == addr_reg)
                begin
                    res_push      = 1'b1;
                    res_in.status = STAT_CLEARED;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == AW'(STORE - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (cmd_pop)
                    begin
                        case (cmd_info.kind)
                            K_DRAW:       state_reg <= S_DRAW;
                            K_READ:       state_reg <= S_READ;
                            K_FILL_DEPTH: state_reg <= S_FILL;
                            K_FILL_PIXEL: state_reg <= S_FILL;
                            default:      state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_DRAW, S_READ:
                begin
                    state_reg <= S_IDLE;
                end
                S_FILL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == addr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the request being worked on
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            info_reg <= cmd_info;
            addr_reg <= cmd_addr;
        end
    end

    dtps_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE)
    ) u_depth_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (waddr),
        .wdata (d_wdata),
        .re    (rd_en),
        .raddr (cmd_addr),
        .rdata (d_rdata)
    );

    dtps_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (waddr),
        .wdata (p_wdata),
        .re    (rd_en),
        .raddr (cmd_addr),
        .rdata (p_rdata)
    );

    dtps_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (res_pop),
        .rdata (res_q),
        .empty (res_empty)
    );

    assign res_data = res_q;

endmodule

`default_nettype wire

// ===== src/depth_tested_pixel_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// --------  -----------------  ----------------------------------------------
// config    cfg_we             cfg_index (3), cfg_data (32)
// request   push / full        opcode, pos_x, pos_y, pos_z, pixel_word, batch_last
// result    pop / empty        status, pixel_out, depth_out, result_last
//
// After reset the depth and pixel stores are zeroed, one word a cycle:
// full stays high until all MAX_WIDTH*MAX_HEIGHT words (32768 by default) are written.
// The back end handles one request at a time: clipped draws and reads
// outside the screen are answered as they are taken, draws and reads do one
// memory read, then compare and write, and clears take the request, then
// write one store word per cell of the area (no writes when it is empty).
// Two-entry queues sit on the request and result sides, so requests keep
// arriving while results wait for pop.

module depth_tested_pixel_store
    import dtps_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration writes
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [WORD_BITS-1:0]        cfg_data,
    // request side
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [1:0]                  opcode,
    input  wire logic signed [15:0]          pos_x,
    input  wire logic signed [15:0]          pos_y,
    input  wire logic signed [WORD_BITS-1:0] pos_z,
    input  wire logic [WORD_BITS-1:0]        pixel_word,
    input  wire logic                        batch_last,
    // result side
    input  wire logic                        pop,
    output logic                             empty,
    output logic [2:0]                       status,
    output logic [WORD_BITS-1:0]             pixel_out,
    output logic signed [WORD_BITS-1:0]      depth_out,
    output logic                             result_last
);

    // Both stores are addressed as y*w+x
    localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;

    logic      init_busy;
    logic      cmd_pop;
    logic      cmd_empty;
    cmd_info_t cmd_info;
    logic [AW-1:0] cmd_addr;
    res_t      res_data;

    // Front: config registers, clipping, address and clamp, request queue
    dtps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .pixel_word (pixel_word),
        .batch_last (batch_last),
        .init_busy  (init_busy),
        .cmd_pop    (cmd_pop),
        .cmd_empty  (cmd_empty),
        .cmd_info   (cmd_info),
        .cmd_addr   (cmd_addr)
    );

    // Back: store sweep, depth test read-modify-write, fills, reads
    dtps_back #(
        .STORE (STORE),
        .AW    (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_busy (init_busy),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd_info  (cmd_info),
        .cmd_addr  (cmd_addr),
        .res_pop   (pop),
        .res_empty (empty),
        .res_data  (res_data)
    );

    // Drive the oldest waiting result
    assign status      = res_data.status;
    assign pixel_out   = res_data.pixel;
    assign depth_out   = res_data.depth;
    assign result_last = res_data.last;

endmodule

`default_nettype wire

// ===== tb/dtps_scoreboard.sv =====
`timescale 1ns / 1ps

// Watches the config, request and result channels of the depth-tested pixel
// store, keeps its own copy of both stores and the registers, and checks every
// popped result against the oldest outstanding prediction.
module dtps_scoreboard
    import dtps_pkg::*;
#(
    parameter int MAX_W = 256,
    parameter int MAX_H = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [WORD_BITS-1:0]     cfg_data,
    input  logic                     push,
    input  logic                     full,
    input  logic [1:0]               opcode,
    input  logic signed [15:0]       pos_x,
    input  logic signed [15:0]       pos_y,
    input  logic signed [31:0]       pos_z,
    input  logic [WORD_BITS-1:0]     pixel_word,
    input  logic                     batch_last,
    input  logic                     pop,
    input  logic                     empty,
    input  logic [2:0]               status,
    input  logic [WORD_BITS-1:0]     pixel_out,
    input  logic signed [31:0]       depth_out,
    input  logic                     result_last,
    output int                       err_count,
    output int                       pending
);

    localparam int CELLS = MAX_W * MAX_H;

    logic signed [31:0]   depth_mem [CELLS];
    logic [WORD_BITS-1:0] pixel_mem [CELLS];

    logic [8:0]           scr_w;
    logic [7:0]           scr_h;
    logic signed [31:0]   clr_depth;
    logic signed [31:0]   z_floor;
    logic signed [31:0]   z_ceil;
    logic [WORD_BITS-1:0] clr_pixel;

    res_t                 due_results [$];
    res_t                 want;
    int                   results_seen;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] wanted);
        $display("[%0t] result %0d: %s got %0h, want %0h",
                 $time, results_seen, field, got, wanted);
        err_count++;
    endtask

    function automatic int active_cols();
        return (int'(scr_w) > MAX_W) ? MAX_W : int'(scr_w);
    endfunction

    function automatic int active_rows();
        return (int'(scr_h) > MAX_H) ? MAX_H : int'(scr_h);
    endfunction

    function automatic bit locate_cell(input logic signed [15:0] x, input logic signed [15:0] y,
                                       output int slot);
        int xi;
        int yi;
        xi = int'(x);
        yi = int'(y);
        slot = yi * active_cols() + xi;
        return !(xi < 0 || yi < 0 || xi >= active_cols() || yi >= active_rows());
    endfunction

    // Apply one request to the shadow stores and return the status it earns.
    function automatic res_t resolve_request(input opcode_t op,
                                             input logic signed [15:0] x,
                                             input logic signed [15:0] y,
                                             input logic signed [31:0] z,
                                             input logic [WORD_BITS-1:0] word,
                                             input logic last);
        res_t               r;
        int                 slot;
        int                 i;
        int                 area;
        logic signed [31:0] fill;
        r = '0;
        r.last = last;
        area = active_cols() * active_rows();
        case (op)
            OP_DRAW:
            begin
                if (!locate_cell(x, y, slot))
                    r.status = STAT_CLIPPED;
                else if (z < depth_mem[slot])
                    r.status = STAT_REJECTED;
                else
                begin
                    depth_mem[slot] = z;
                    pixel_mem[slot] = word;
                    r.status = STAT_WRITTEN;
                end
            end
            OP_CLEAR_DEPTH:
            begin
                // when the two are inverted, below the floor takes the floor, any other the ceiling
                fill = clr_depth;
                if (clr_depth < z_floor)
                    fill = z_floor;
                else if (clr_depth > z_ceil)
                    fill = z_ceil;
                for (i = 0; i < area; i++)
                    depth_mem[i] = fill;
                r.status = STAT_CLEARED;
            end
            OP_CLEAR_PIXEL:
            begin
                for (i = 0; i < area; i++)
                    pixel_mem[i] = clr_pixel;
                r.status = STAT_CLEARED;
            end
            default:
            begin
                if (locate_cell(x, y, slot))
                begin
                    r.status = STAT_READ_OK;
                    r.pixel  = pixel_mem[slot];
                    r.depth  = depth_mem[slot];
                end
                else
                    r.status = STAT_READ_OUTSIDE;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (depth_mem[i])
            begin
                depth_mem[i] = '0;
                pixel_mem[i] = '0;
            end
            scr_w        = 9'd256;
            scr_h        = 8'd128;
            clr_depth    = 32'sd0;
            z_floor      = 32'sh8000_0000;
            z_ceil       = 32'sh7FFF_FFFF;
            clr_pixel    = '0;
            results_seen = 0;
            due_results.delete();
            pending      = 0;
        end
        else
        begin
            // retire first: a result popped now belongs to an earlier request
            if (pop && !empty)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result with nothing outstanding, status",
                                    32'(status), '0);
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (pixel_out !== want.pixel)
                        report_mismatch("pixel_out", pixel_out, want.pixel);
                    if (depth_out !== want.depth)
                        report_mismatch("depth_out", depth_out, want.depth);
                    if (result_last !== want.last)
                        report_mismatch("result_last", 32'(result_last), 32'(want.last));
                end
                results_seen++;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  scr_w     = cfg_data[8:0];
                    REG_SCREEN_HEIGHT: scr_h     = cfg_data[7:0];
                    REG_CLEAR_DEPTH:   clr_depth = cfg_data;
                    REG_DEPTH_FLOOR:   z_floor   = cfg_data;
                    REG_DEPTH_CEILING: z_ceil    = cfg_data;
                    REG_CLEAR_PIXEL:   clr_pixel = cfg_data;
                    default: ;
                endcase
            end

            if (push && !full)
                due_results.push_back(resolve_request(opcode_t'(opcode), pos_x, pos_y, pos_z,
                                                      pixel_word, batch_last));

            pending = due_results.size();
        end
    end

endmodule

// ===== tb/tb_depth_tested_pixel_store.sv =====
`timescale 1ns / 1ps

// Top of the depth-tested pixel store bench. It only makes stimulus and gives
// the verdict; dtps_scoreboard does all prediction and comparison.
module tb_depth_tested_pixel_store;
    import dtps_pkg::*;

    localparam int MAX_W           = 256;
    localparam int MAX_H           = 128;
    localparam int RESET_CYCLES    = 11;
    // Full-screen clears write all 32768 cells, so random phases only clear
    // when the active area is at most this many cells.
    localparam int SMALL_AREA      = 512;
    // Most coordinates fall in this corner so that reads hit earlier draws.
    localparam int HOT_SPAN        = 12;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 100;
    // Longest request (a clear) has finished once its result is out; the
    // settle time covers the queues before a register write or the verdict.
    localparam int SETTLE_CYCLES   = 8;
    // Slowest correct run: reset sweep plus two full-screen clears, at most
    // ~120 small clears of up to 512 cells, ~930 requests behind long pop
    // stalls; the limit allows several times that.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // register indexes the block does not decode
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        cfg_we     = 1'b0;
    logic [2:0]                  cfg_index  = '0;
    logic [WORD_BITS-1:0]        cfg_data   = '0;
    logic                        push       = 1'b0;
    logic                        full;
    logic [1:0]                  opcode     = '0;
    logic signed [15:0]          pos_x      = '0;
    logic signed [15:0]          pos_y      = '0;
    logic signed [WORD_BITS-1:0] pos_z      = '0;
    logic [WORD_BITS-1:0]        pixel_word = '0;
    logic                        batch_last = 1'b0;
    logic                        pop        = 1'b0;
    logic                        empty;
    logic [2:0]                  status;
    logic [WORD_BITS-1:0]        pixel_out;
    logic signed [WORD_BITS-1:0] depth_out;
    logic                        result_last;

    int                          err_count;
    int                          pending;

    int                          burst_left  = 0;
    int                          cols_now    = MAX_W;
    int                          rows_now    = MAX_H;
    int unsigned                 cycle_count = 0;
    int                          pop_mode    = 0;
    int                          pop_mode_left = 0;

    always #5 clk = ~clk;

    depth_tested_pixel_store #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .pixel_word  (pixel_word),
        .batch_last  (batch_last),
        .pop         (pop),
        .empty       (empty),
        .status      (status),
        .pixel_out   (pixel_out),
        .depth_out   (depth_out),
        .result_last (result_last)
    );

    dtps_scoreboard #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .pixel_word  (pixel_word),
        .batch_last  (batch_last),
        .pop         (pop),
        .empty       (empty),
        .status      (status),
        .pixel_out   (pixel_out),
        .depth_out   (depth_out),
        .result_last (result_last),
        .err_count   (err_count),
        .pending     (pending)
    );

    // Watchdog: end the run as failed if it outlasts CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Pop side: switch at random between stall patterns - always pop, coin
    // flip, mostly stalled, mostly popping.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop           <= 1'b0;
            pop_mode      <= 0;
            pop_mode_left <= 0;
        end
        else
        begin
            if (pop_mode_left == 0)
            begin
                pop_mode      <= $urandom_range(0, 3);
                pop_mode_left <= $urandom_range(20, 200);
            end
            else
                pop_mode_left <= pop_mode_left - 1;
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= ($urandom_range(0, 7) == 0);
                default: pop <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // Write one register; hold the strobe for exactly one edge.
    task automatic write_reg(input logic [2:0] idx, input logic [WORD_BITS-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Track the geometry the block will use, clamped as it clamps it.
    task automatic set_geometry(input logic [WORD_BITS-1:0] wdata,
                                input logic [WORD_BITS-1:0] hdata);
        write_reg(REG_SCREEN_WIDTH, wdata);
        write_reg(REG_SCREEN_HEIGHT, hdata);
        cols_now = (int'(wdata[8:0]) > MAX_W) ? MAX_W : int'(wdata[8:0]);
        rows_now = (int'(hdata[7:0]) > MAX_H) ? MAX_H : int'(hdata[7:0]);
    endtask

    // Present one request and hold it until an edge takes it.
    task automatic send_item(input opcode_t op, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic [31:0] z,
                             input logic [WORD_BITS-1:0] word, input logic last);
        push       <= 1'b1;
        opcode     <= op;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        pixel_word <= word;
        batch_last <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Sender pacing: bursts of random length, each followed by a gap that is
    // sometimes zero so that long back-to-back stretches also occur.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Drop push, wait for every outstanding result, then let the block settle.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // New random setting for every register.
    task automatic configure_random();
        logic [WORD_BITS-1:0] wdata;
        logic [WORD_BITS-1:0] hdata;
        wdata = $urandom;
        hdata = $urandom;
        case ($urandom_range(0, 9))
            0:       wdata[8:0] = 9'd0;
            1:       wdata[8:0] = 9'd1;
            2:       wdata[8:0] = 9'($urandom_range(257, 511));
            3:       wdata[8:0] = 9'd256;
            default: wdata[8:0] = 9'($urandom_range(2, 24));
        endcase
        case ($urandom_range(0, 9))
            0:       hdata[7:0] = 8'd0;
            1:       hdata[7:0] = 8'd1;
            2:       hdata[7:0] = 8'($urandom_range(129, 255));
            3:       hdata[7:0] = 8'd128;
            default: hdata[7:0] = 8'($urandom_range(2, 12));
        endcase
        set_geometry(wdata, hdata);
        write_reg(REG_CLEAR_DEPTH, $urandom_range(0, 1) ? $urandom_range(0, 12) - 6 : $urandom);
        case ($urandom_range(0, 3))
            0:
            begin
                write_reg(REG_DEPTH_FLOOR, 32'h8000_0000);
                write_reg(REG_DEPTH_CEILING, 32'h7FFF_FFFF);
            end
            1:
            begin
                write_reg(REG_DEPTH_FLOOR, -3);
                write_reg(REG_DEPTH_CEILING, 3);
            end
            2:
            begin
                // inverted window
                write_reg(REG_DEPTH_FLOOR, 3);
                write_reg(REG_DEPTH_CEILING, -3);
            end
            default:
            begin
                write_reg(REG_DEPTH_FLOOR, $urandom);
                write_reg(REG_DEPTH_CEILING, $urandom);
            end
        endcase
        write_reg(REG_CLEAR_PIXEL, $urandom);
        // undecoded indexes must leave every register alone
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
    endtask

    // One random request: mostly draws and reads near the origin so depth
    // tests and read-backs meet earlier draws; some at the edges, some noise.
    task automatic random_request();
        int                   roll;
        bit                   roomy;
        bit                   on_area;
        opcode_t              op;
        logic signed [15:0]   x;
        logic signed [15:0]   y;
        logic [31:0]          z;
        roomy   = (cols_now * rows_now) <= SMALL_AREA;
        on_area = (cols_now > 0) && (rows_now > 0);

        roll = $urandom_range(0, 99);
        if (roll < 50)
            op = OP_DRAW;
        else if (roll < 88)
            op = OP_READ;
        else if (roll < 94)
            op = roomy ? OP_CLEAR_DEPTH : OP_DRAW;
        else
            op = roomy ? OP_CLEAR_PIXEL : OP_READ;

        roll = $urandom_range(0, 99);
        if (on_area && roll < 60)
        begin
            x = 16'($urandom_range(0, ((cols_now < HOT_SPAN) ? cols_now : HOT_SPAN) - 1));
            y = 16'($urandom_range(0, ((rows_now < HOT_SPAN) ? rows_now : HOT_SPAN) - 1));
        end
        else if (on_area && roll < 80)
        begin
            x = 16'($urandom_range(0, cols_now - 1));
            y = 16'($urandom_range(0, rows_now - 1));
        end
        else if (roll < 90)
        begin
            // just past the right or bottom edge, or one below zero
            x = 16'($urandom_range(0, 1) ? cols_now : -1);
            y = 16'($urandom_range(0, 1) ? rows_now : $urandom_range(0, rows_now));
            if ($urandom_range(0, 1))
            begin
                x = y;
                y = 16'($urandom_range(0, 1) ? rows_now : -1);
            end
        end
        else
        begin
            x = 16'($urandom);
            y = 16'($urandom);
        end

        roll = $urandom_range(0, 99);
        if (roll < 50)
            z = $urandom_range(0, 16) - 8;
        else if (roll < 60)
            z = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else
            z = $urandom;

        send_item(op, x, y, z, $urandom, 1'($urandom_range(0, 1)));
        pace();
    endtask

    initial
    begin
        int ph;

        // Hold reset, then release; the block sweeps both stores to zero
        // with full high, so the first request just waits for it.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset geometry 256x128: equal depth, extremes, clipping on all sides.
        send_item(OP_READ, 0, 0, 0, 0, 1'b0);
        send_item(OP_DRAW, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_DRAW, 255, 127, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0);
        send_item(OP_DRAW, 255, 127, 32'h8000_0000, 32'hDEAD_BEEF, 1'b1);
        send_item(OP_DRAW, 256, 0, 0, 32'h0000_0001, 1'b0);
        send_item(OP_DRAW, 0, 128, 0, 32'h0000_0002, 1'b0);
        send_item(OP_DRAW, -1, -1, 0, 32'h0000_0003, 1'b1);
        send_item(OP_DRAW, -32768, 32767, 32'h7FFF_FFFF, 32'h0, 1'b0);
        send_item(OP_READ, 255, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_READ, 32767, -32768, 0, 0, 1'b0);
        // full-screen clears with the reset register values
        send_item(OP_CLEAR_DEPTH, 0, 0, 0, 0, 1'b1);
        send_item(OP_CLEAR_PIXEL, 0, 0, 0, 0, 1'b0);
        send_item(OP_READ, 255, 127, 0, 0, 1'b1);
        wait_idle();

        // Oversized geometry clamps to the maximum; upper data bits ignored.
        set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_DRAW, 255, 127, 1, 32'hCAFE_F00D, 1'b1);
        send_item(OP_READ, 255, 127, 0, 0, 1'b0);
        send_item(OP_READ, 256, 127, 0, 0, 1'b1);
        wait_idle();

        // Tiny 4x2 screen, clear depth below the floor of an inverted window.
        set_geometry(4, 2);
        write_reg(REG_CLEAR_DEPTH, 32'h8000_0000);
        write_reg(REG_DEPTH_FLOOR, 5);
        write_reg(REG_DEPTH_CEILING, -5);
        write_reg(REG_CLEAR_PIXEL, 32'hFFFF_FFFF);
        send_item(OP_CLEAR_DEPTH, 0, 0, 0, 0, 1'b0);
        send_item(OP_DRAW, 3, 1, 4, 32'h5555_AAAA, 1'b0);
        send_item(OP_DRAW, 3, 1, 5, 32'hAAAA_5555, 1'b1);
        send_item(OP_READ, 3, 1, 0, 0, 1'b0);
        wait_idle();

        // Clear depth inside the floor but above the ceiling takes the ceiling.
        write_reg(REG_CLEAR_DEPTH, 0);
        write_reg(REG_DEPTH_FLOOR, -10);
        write_reg(REG_DEPTH_CEILING, -20);
        send_item(OP_CLEAR_DEPTH, 0, 0, 0, 0, 1'b1);
        send_item(OP_CLEAR_PIXEL, 0, 0, 0, 0, 1'b0);
        send_item(OP_READ, 0, 0, 0, 0, 1'b1);
        wait_idle();

        // Zero width: nothing inside, clears still report cleared.
        set_geometry(0, 5);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        send_item(OP_DRAW, 0, 0, 32'h7FFF_FFFF, 32'h1, 1'b0);
        send_item(OP_READ, 0, 0, 0, 0, 1'b1);
        send_item(OP_CLEAR_DEPTH, 0, 0, 0, 0, 1'b0);
        send_item(OP_CLEAR_PIXEL, 0, 0, 0, 0, 1'b1);
        wait_idle();

        // Random phases, each with a fresh register setting.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            configure_random();
            repeat (ITEMS_PER_PHASE) random_request();
            wait_idle();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
